>>> hdl/kdm_pkg.sv
// Shared types and constants for the keypad scan and display multiplexer.
`default_nettype none

package kdm_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LOCKOUT_TICKS = 1'b0,
        REG_IDLE_LIMIT    = 1'b1
    } t_cfg_index;

    localparam logic [7:0]  LOCKOUT_TICKS_RESET = 8'd70;
    localparam logic [15:0] IDLE_LIMIT_RESET    = 16'd40000;
    localparam logic [7:0]  SEG_RESET_BLANK     = 8'hFF;
    localparam logic [7:0]  SEG_RESET_LAST      = 8'hC0;

    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_WRITE = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] row_lines;
        logic [1:0] digit_index;
        logic [7:0] segment_pattern;
    } t_item;

    typedef struct packed {
        logic [3:0] digit_strobe;
        logic [7:0] segments;
        logic       key_valid;
        logic [1:0] key_row;
        logic [1:0] key_column;
        logic       idle_timeout;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/kdm_scan_core.sv
// Scanner state, digit store and the per-beat result logic.
`default_nettype none

module kdm_scan_core
    import kdm_pkg::*;
#(
    parameter int NUM_DIGITS = 4
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire [CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]    i_cfg_data,
    input  wire                     i_fire,
    input  wire t_item              i_item,
    output t_result                 o_result
);

    localparam int STROBE_W = (NUM_DIGITS > 4) ? NUM_DIGITS : 4;

    logic [7:0]            r_lockout_ticks;
    logic [15:0]           r_idle_limit;
    logic [NUM_DIGITS-1:0] r_ring;
    logic [7:0]            r_lockout_count;
    logic                  r_press_allowed;
    logic [15:0]           r_idle_count;
    logic [7:0]            r_store [NUM_DIGITS];

    logic [NUM_DIGITS-1:0] n_ring;
    logic [7:0]            n_lockout_count;
    logic                  n_press_allowed;
    logic [15:0]           n_idle_count;
    logic [STROBE_W-1:0]   strobe_wide;
    logic [7:0]            seg_sel;
    logic [1:0]            col_sel;
    logic [3:0]            rows_m1;
    logic [2:0]            row_ones;
    logic                  key_hit;
    logic                  timeout;

    always_comb begin
        n_ring = {r_ring[NUM_DIGITS-2:0], r_ring[NUM_DIGITS-1]};
        seg_sel = '0;
        col_sel = '0;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (n_ring[k]) begin
                seg_sel = seg_sel | r_store[k];
                col_sel = col_sel | 2'(k);
            end
        end
        strobe_wide = STROBE_W'(n_ring);

        rows_m1  = i_item.row_lines - 4'd1;
        row_ones = 3'(rows_m1[0]) + 3'(rows_m1[1]) + 3'(rows_m1[2]) + 3'(rows_m1[3]);

        // The lockout counter re-arms the press gate before this beat's rows are looked at.
        n_lockout_count = r_lockout_count + 8'd1;
        n_press_allowed = r_press_allowed;
        if (n_lockout_count > r_lockout_ticks) begin
            n_press_allowed = 1'b1;
            n_lockout_count = '0;
        end

        key_hit      = 1'b0;
        timeout      = 1'b0;
        n_idle_count = r_idle_count;
        if (i_item.row_lines != 4'd0) begin
            if (n_press_allowed) begin
                key_hit         = 1'b1;
                n_press_allowed = 1'b0;
                n_lockout_count = '0;
            end
            n_idle_count = '0;
        end else begin
            n_idle_count = r_idle_count + 16'd1;
            if (n_idle_count > r_idle_limit) begin
                n_idle_count    = '0;
                n_lockout_count = '0;
                timeout         = 1'b1;
            end
        end

        o_result.digit_strobe = strobe_wide[3:0];
        o_result.segments     = seg_sel;
        o_result.key_valid    = key_hit;
        o_result.key_row      = key_hit ? row_ones[1:0] : 2'd0;
        o_result.key_column   = key_hit ? col_sel : 2'd0;
        o_result.idle_timeout = timeout;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout_ticks <= LOCKOUT_TICKS_RESET;
            r_idle_limit    <= IDLE_LIMIT_RESET;
            r_ring          <= NUM_DIGITS'(1);
            r_lockout_count <= '0;
            r_press_allowed <= 1'b1;
            r_idle_count    <= '0;
            for (int k = 0; k < NUM_DIGITS; k++) begin
                r_store[k] <= (k == NUM_DIGITS - 1) ? SEG_RESET_LAST : SEG_RESET_BLANK;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    REG_LOCKOUT_TICKS: r_lockout_ticks <= i_cfg_data[7:0];
                    REG_IDLE_LIMIT:    r_idle_limit    <= i_cfg_data;
                endcase
            end
            if (i_fire) begin
                if (i_item.kind == KIND_WRITE) begin
                    for (int k = 0; k < NUM_DIGITS; k++) begin
                        if (32'(i_item.digit_index) == k) begin
                            r_store[k] <= i_item.segment_pattern;
                        end
                    end
                end else begin
                    r_ring          <= n_ring;
                    r_lockout_count <= n_lockout_count;
                    r_press_allowed <= n_press_allowed;
                    r_idle_count    <= n_idle_count;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/keypad_scan_display_mux.sv
// Top level: input register, scan core and output register of the display and keypad scanner.
//
// Use: each input beat is either a scan tick (kind 0, with sampled row lines) or a write
// of one digit's active-low segment byte (kind 1). Every tick yields one result beat with
// the rotated digit strobe (also the keypad column drive), that digit's segments, an
// optional key report (row and column) and an idle timeout pulse. Writes yield nothing.
// Configuration: a write enable, index and data; index 0 sets the lockout ticks,
// index 1 the idle limit. Write it only while no beat is in flight.
// Path: a tick is captured in the input register, passes through the scan core and is
// captured in the output register once the output slot is free or draining.
// Throughput: one beat per cycle while the output beat is taken; the single combinational
// pass between the input and output registers sets that figure.
// Reset: the strobe starts at digit 0 (the first tick shows digit 1), presses are
// allowed, counters clear, and all digits show blank except the last, which shows 0.
// Stall: while the output beat is not taken, the input register holds its tick and
// input ready drops; write beats still drain because they make no result.
`default_nettype none

module keypad_scan_display_mux
    import kdm_pkg::*;
#(
    parameter int NUM_DIGITS = 4
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire [CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]    i_cfg_data,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  wire                     i_kind,
    input  wire [3:0]               i_row_lines,
    input  wire [1:0]               i_digit_index,
    input  wire [7:0]               i_segment_pattern,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output logic [3:0]              o_digit_strobe,
    output logic [7:0]              o_segments,
    output logic                    o_key_valid,
    output logic [1:0]              o_key_row,
    output logic [1:0]              o_key_column,
    output logic                    o_idle_timeout
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result core_result;
    logic    advance;

    // A write beat needs no output slot; a tick needs the output register free or draining.
    assign advance    = r_in_valid &&
                        ((r_in.kind == KIND_WRITE) || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    kdm_scan_core #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (advance),
        .i_item      (r_in),
        .o_result    (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance && (r_in.kind == KIND_TICK)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.kind            <= t_kind'(i_kind);
            r_in.row_lines       <= i_row_lines;
            r_in.digit_index     <= i_digit_index;
            r_in.segment_pattern <= i_segment_pattern;
        end
        if (advance && (r_in.kind == KIND_TICK)) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_digit_strobe = r_out.digit_strobe;
    assign o_segments     = r_out.segments;
    assign o_key_valid    = r_out.key_valid;
    assign o_key_row      = r_out.key_row;
    assign o_key_column   = r_out.key_column;
    assign o_idle_timeout = r_out.idle_timeout;

endmodule

`default_nettype wire
